>>> design/crc8bs_pkg.sv
`default_nettype none
package crc8bs_pkg;

  // degree of the generator polynomial
  localparam int CRC_WIDTH = 8;
  // width of the configuration write data
  localparam int CFG_W = 8;
  // counter for the remainder bits still to send, holds CRC_WIDTH itself
  localparam int CNT_W = $clog2(CRC_WIDTH + 1);

  // x^8+x^5+x^3+x without the leading term
  localparam logic [CFG_W-1:0] GEN_RESET = CFG_W'(42);

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_CHECK  = 1'b1
  } op_t;

  typedef struct packed {
    logic step;
    logic data_bit;
    logic last;
  } step_t;

  typedef struct packed {
    logic [CRC_WIDTH-1:0] crc;
    logic                 zero;
  } div_res_t;

endpackage
`default_nettype wire

>>> design/crc8bs_in_if.sv
`default_nettype none
interface crc8bs_in_if;
  logic valid;
  logic ready;
  logic operation;
  logic data_bit;
  logic last_bit;

  modport source (output valid, output operation, output data_bit, output last_bit,
                  input ready);
  modport sink (input valid, input operation, input data_bit, input last_bit,
                output ready);
endinterface
`default_nettype wire

>>> design/crc8bs_out_if.sv
`default_nettype none
interface crc8bs_out_if;
  logic valid;
  logic ready;
  logic out_bit;
  logic is_verdict;
  logic check_ok;
  logic end_of_run;

  modport source (output valid, output out_bit, output is_verdict, output check_ok,
                  output end_of_run, input ready);
  modport sink (input valid, input out_bit, input is_verdict, input check_ok,
                input end_of_run, output ready);
endinterface
`default_nettype wire

>>> design/crc8bs_cfg_if.sv
`default_nettype none
interface crc8bs_cfg_if;
  import crc8bs_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/crc8bs_div.sv
`default_nettype none
module crc8bs_div (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire crc8bs_pkg::step_t                  ctl,
  input  wire logic [crc8bs_pkg::CRC_WIDTH-1:0]   gen,
  output crc8bs_pkg::div_res_t                    res
);
  import crc8bs_pkg::*;

  // plain remainder of the bits so far, used for the verdict and the crc
  logic [CRC_WIDTH-1:0] rem_r, rem_nxt;
  // remainder of the message times x^CRC_WIDTH, used for the appended crc
  logic [CRC_WIDTH-1:0] crc_acc;

  logic [CRC_WIDTH:0] shifted;

  always_comb begin
    shifted = {rem_r, ctl.data_bit};
    rem_nxt = shifted[CRC_WIDTH] ? (shifted[CRC_WIDTH-1:0] ^ gen) : shifted[CRC_WIDTH-1:0];
    // shift CRC_WIDTH zero bits through the current generator
    crc_acc = rem_nxt;
    for (int i = 0; i < CRC_WIDTH; i++) begin
      crc_acc = crc_acc[CRC_WIDTH-1] ? ({crc_acc[CRC_WIDTH-2:0], 1'b0} ^ gen)
                                     : {crc_acc[CRC_WIDTH-2:0], 1'b0};
    end
  end

  assign res.crc  = crc_acc;
  assign res.zero = (rem_nxt == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (ctl.step) begin
      // cleared after each last bit
      rem_r <= ctl.last ? '0 : rem_nxt;
    end
  end
endmodule
`default_nettype wire

>>> design/crc8_bit_serial_encode_check.sv
// bit-serial crc encoder and checker, generator of degree 8 (default x^8+x^5+x^3+x)
// in_ch: one message bit per beat, msb first, with operation (0 encode, 1 check)
//   and last_bit marking the final bit of a message
// out_ch: result beats; encode echoes every data bit and after the last bit sends
//   the 8 crc bits msb first; check sends only one verdict beat on the last bit
// cfg_ch: writes the generator coefficients below x^8; the user must write it only
//   while no beat is in flight, the block does not enforce it
// latency: a result appears on out_ch the cycle after its input beat is accepted
// throughput: one input beat per cycle unless out_ch stalls; an encode last
//   bit holds in_ch off while the crc bits go out through the single output register
// check beats that are not last produce no result
// stall: a full output register not taken by the sink holds in_ch ready low;
//   an input beat is taken in the same cycle the waiting result is taken
// reset (rst_n low, synchronous): remainder cleared, generator back to 42,
//   output register empty, no crc bits pending
`default_nettype none
module crc8_bit_serial_encode_check (
  input wire logic   clk,
  input wire logic   rst_n,
  crc8bs_in_if.sink  in_ch,
  crc8bs_out_if.source out_ch,
  crc8bs_cfg_if.sink cfg_ch
);
  import crc8bs_pkg::*;

  // generator register
  logic [CRC_WIDTH-1:0] gen_r;

  // output register
  logic out_valid_r, out_valid_nxt;
  logic out_bit_r, out_bit_nxt;
  logic is_verdict_r, is_verdict_nxt;
  logic check_ok_r, check_ok_nxt;
  logic end_of_run_r, end_of_run_nxt;

  // crc bits waiting to go out after an encode last bit
  logic [CRC_WIDTH-1:0] crc_sh_r, crc_sh_nxt;
  logic [CNT_W-1:0]     burst_cnt_r, burst_cnt_nxt;

  logic     slot_free;
  logic     in_fire;
  step_t    div_ctl;
  div_res_t div_res;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= CRC_WIDTH'(GEN_RESET);
    end else if (cfg_ch.valid) begin
      // bits at or above the degree are dropped
      gen_r <= CRC_WIDTH'(cfg_ch.data);
    end
  end

  // output slot can take a new beat this cycle
  assign slot_free   = !out_valid_r || out_ch.ready;
  // no new input while crc bits are still going out
  assign in_ch.ready = slot_free && (burst_cnt_r == '0);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign div_ctl.step     = in_fire;
  assign div_ctl.data_bit = in_ch.data_bit;
  assign div_ctl.last     = in_ch.last_bit;

  crc8bs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .gen   (gen_r),
    .res   (div_res)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_bit_nxt    = out_bit_r;
    is_verdict_nxt = is_verdict_r;
    check_ok_nxt   = check_ok_r;
    end_of_run_nxt = end_of_run_r;
    crc_sh_nxt     = crc_sh_r;
    burst_cnt_nxt  = burst_cnt_r;

    if (slot_free) begin
      out_valid_nxt = 1'b0;
      if (burst_cnt_r != '0) begin
        // next crc bit, msb first; end of run on the final one
        out_valid_nxt  = 1'b1;
        out_bit_nxt    = crc_sh_r[CRC_WIDTH-1];
        is_verdict_nxt = 1'b0;
        check_ok_nxt   = 1'b0;
        end_of_run_nxt = (burst_cnt_r == CNT_W'(1));
        crc_sh_nxt     = {crc_sh_r[CRC_WIDTH-2:0], 1'b0};
        burst_cnt_nxt  = burst_cnt_r - CNT_W'(1);
      end else if (in_fire) begin
        if (op_t'(in_ch.operation) == OP_ENCODE) begin
          // echo the data bit
          out_valid_nxt  = 1'b1;
          out_bit_nxt    = in_ch.data_bit;
          is_verdict_nxt = 1'b0;
          check_ok_nxt   = 1'b0;
          end_of_run_nxt = 1'b0;
          if (in_ch.last_bit) begin
            crc_sh_nxt    = div_res.crc;
            burst_cnt_nxt = CNT_W'(CRC_WIDTH);
          end
        end else if (in_ch.last_bit) begin
          // check verdict on the whole received word
          out_valid_nxt  = 1'b1;
          out_bit_nxt    = 1'b0;
          is_verdict_nxt = 1'b1;
          check_ok_nxt   = div_res.zero;
          end_of_run_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      burst_cnt_r <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      burst_cnt_r <= burst_cnt_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    out_bit_r    <= out_bit_nxt;
    is_verdict_r <= is_verdict_nxt;
    check_ok_r   <= check_ok_nxt;
    end_of_run_r <= end_of_run_nxt;
    crc_sh_r     <= crc_sh_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_bit    = out_bit_r;
  assign out_ch.is_verdict = is_verdict_r;
  assign out_ch.check_ok   = check_ok_r;
  assign out_ch.end_of_run = end_of_run_r;
endmodule
`default_nettype wire
